@@ design/prs_pkg.sv @@
// Package for the particle repel / spring step block: widths, register indexes,
// reset values, item structs and the 32-bit saturation helper.
// No dependencies.
`timescale 1ns / 1ps
package prs_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd4;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_BUTTON = 2'd1;
  localparam logic [1:0] MODE_LATCH  = 2'd2;

  localparam logic [30:0] STRENGTH_RST = 31'd196608000;
  localparam logic [31:0] RADIUS_RST   = 32'd10000;
  localparam logic [15:0] DAMPING_RST  = 16'd58982;
  localparam logic [15:0] RATE_RST     = 16'd6554;

  localparam int S_W   = 24;          // distance magnitude, Q.8
  localparam int D2_W  = 2 * S_W;     // squared distance inside the radius
  localparam int R_W   = D2_W / 2;    // integer square root
  localparam int NUM_W = 47;          // strength << 16
  localparam int U_W   = 17;          // unit component, at most 1.0 in Q.16
  localparam int SAT_W = 80;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic [S_W-1:0]     sx;
    logic [S_W-1:0]     sy;
    logic [D2_W-1:0]    d2;
    logic               dx_pos;
    logic               dy_pos;
    logic               touched;
    logic               move;
    logic               apply_f;
  } prs_item_t;

  typedef struct packed {
    logic [31:0] val;
    logic        clip;
  } prs_sat_t;

  function automatic prs_sat_t sat32(input logic signed [SAT_W-1:0] x);
    prs_sat_t r;
    r.clip = (x > SAT_W'(32'sh7fffffff)) || (x < -SAT_W'(33'sh080000000));
    if (!r.clip) r.val = x[31:0];
    else r.val = x[SAT_W-1] ? 32'h80000000 : 32'h7fffffff;
    return r;
  endfunction

endpackage

@@ design/prs_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with sideband payload.
// Depends on prs_pkg.
`timescale 1ns / 1ps
module prs_sqrt import prs_pkg::*; #(
  parameter int PW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [D2_W-1:0]   in_rad,
  input  logic [PW-1:0]     in_pl,
  output logic              out_valid,
  output logic [R_W-1:0]    out_root,
  output logic [PW-1:0]     out_pl
);

  localparam int NS   = R_W;
  localparam int REMW = R_W + 2;

  logic [REMW-1:0] rem_r  [NS];
  logic [R_W-1:0]  root_r [NS];
  logic [D2_W-1:0] rad_r  [NS];
  logic            v_r    [NS];
  logic [PW-1:0]   pl_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [REMW-1:0] rem_i;
    logic [R_W-1:0]  root_i;
    logic [D2_W-1:0] rad_i;
    logic            v_i;
    logic [PW-1:0]   pl_i;
    logic [REMW+1:0] t_w;
    logic [REMW+1:0] trial_w;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign v_i    = in_valid;
      assign pl_i   = in_pl;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign v_i    = v_r[k-1];
      assign pl_i   = pl_r[k-1];
    end

    assign t_w     = {rem_i, rad_i[D2_W-1 -: 2]};
    assign trial_w = (REMW+2)'({root_i, 2'b01});
    assign ge      = t_w >= trial_w;

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? REMW'(t_w - trial_w) : REMW'(t_w);
        root_r[k] <= {root_i[R_W-2:0], ge};
        rad_r[k]  <= {rad_i[D2_W-3:0], 2'b00};
        pl_r[k]   <= pl_i;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_pl    = pl_r[NS-1];

endmodule

@@ design/prs_div.sv @@
// Three-lane pipelined restoring divider (force quotient, x and y unit components),
// one quotient bit per stage, with sideband payload. Depends on prs_pkg.
`timescale 1ns / 1ps
module prs_div import prs_pkg::*; #(
  parameter int PW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num_q,
  input  logic [D2_W-1:0]  den_q,
  input  logic [NUM_W-1:0] num_x,
  input  logic [NUM_W-1:0] num_y,
  input  logic [R_W-1:0]   den_u,
  input  logic [PW-1:0]    in_pl,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo_q,
  output logic [U_W-1:0]   quo_x,
  output logic [U_W-1:0]   quo_y,
  output logic [PW-1:0]    out_pl
);

  localparam int NS = NUM_W;

  logic [D2_W-1:0]  remq_r [NS];
  logic [NUM_W-1:0] qnq_r  [NS];
  logic [D2_W-1:0]  denq_r [NS];
  logic [R_W-1:0]   remx_r [NS];
  logic [NUM_W-1:0] qnx_r  [NS];
  logic [R_W-1:0]   remy_r [NS];
  logic [NUM_W-1:0] qny_r  [NS];
  logic [R_W-1:0]   denu_r [NS];
  logic             v_r    [NS];
  logic [PW-1:0]    pl_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [D2_W-1:0]  remq_i, denq_i;
    logic [NUM_W-1:0] qnq_i, qnx_i, qny_i;
    logic [R_W-1:0]   remx_i, remy_i, denu_i;
    logic             v_i;
    logic [PW-1:0]    pl_i;
    logic [D2_W:0]    sq;
    logic [R_W:0]     sx, sy;
    logic             geq, gex, gey;

    if (k == 0) begin : g_first
      assign remq_i = '0;
      assign qnq_i  = num_q;
      assign denq_i = den_q;
      assign remx_i = '0;
      assign qnx_i  = num_x;
      assign remy_i = '0;
      assign qny_i  = num_y;
      assign denu_i = den_u;
      assign v_i    = in_valid;
      assign pl_i   = in_pl;
    end else begin : g_next
      assign remq_i = remq_r[k-1];
      assign qnq_i  = qnq_r[k-1];
      assign denq_i = denq_r[k-1];
      assign remx_i = remx_r[k-1];
      assign qnx_i  = qnx_r[k-1];
      assign remy_i = remy_r[k-1];
      assign qny_i  = qny_r[k-1];
      assign denu_i = denu_r[k-1];
      assign v_i    = v_r[k-1];
      assign pl_i   = pl_r[k-1];
    end

    assign sq  = {remq_i, qnq_i[NUM_W-1]};
    assign sx  = {remx_i, qnx_i[NUM_W-1]};
    assign sy  = {remy_i, qny_i[NUM_W-1]};
    assign geq = sq >= {1'b0, denq_i};
    assign gex = sx >= {1'b0, denu_i};
    assign gey = sy >= {1'b0, denu_i};

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remq_r[k] <= geq ? D2_W'(sq - {1'b0, denq_i}) : D2_W'(sq);
        qnq_r[k]  <= {qnq_i[NUM_W-2:0], geq};
        denq_r[k] <= denq_i;
        remx_r[k] <= gex ? R_W'(sx - {1'b0, denu_i}) : R_W'(sx);
        qnx_r[k]  <= {qnx_i[NUM_W-2:0], gex};
        remy_r[k] <= gey ? R_W'(sy - {1'b0, denu_i}) : R_W'(sy);
        qny_r[k]  <= {qny_i[NUM_W-2:0], gey};
        denu_r[k] <= denu_i;
        pl_r[k]   <= pl_i;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign quo_q     = qnq_r[NS-1];
  assign quo_x     = qnx_r[NS-1][U_W-1:0];
  assign quo_y     = qny_r[NS-1][U_W-1:0];
  assign out_pl    = pl_r[NS-1];

endmodule

@@ design/particle_repel_spring_step.sv @@
// Particle repel / spring step: streaming top level with config registers,
// front stages, update stages and output skid buffer.
// Depends on prs_pkg, prs_sqrt, prs_div.
//
// Usage:
//  - in_* carries one particle per transaction: tdata holds positions,
//    velocities, home and pointer coordinates; tuser holds the touched flag
//    and pointer button. out_* returns the updated particle, one transaction
//    per input transaction, in order.
//  - cfg_* writes mode, force strength, radius, damping and return rate;
//    cfg_ready is always high. Write only while the block is drained.
//  - Throughput: one particle per clock, sustained while in_tready stays high.
//  - Pipeline: the transaction enters the first of 79 register stages at
//    the accepting edge (3 front stages, 24 square-root stages, 47 divider
//    stages, 4 update stages, output reg).
//    The long chain is set by the bit-per-stage root and quotient units.
//  - Stall: the whole pipeline advances together; a 2-entry output buffer
//    (output register plus skid) lets one more result land while the
//    receiver holds out_tready low. in_tready drops only when the skid is
//    full and comes back the cycle after the receiver takes a result.
//  - Reset (rst_n low, synchronous): all valid bits clear, config registers
//    return to their defaults. No clearing pass is needed.
`timescale 1ns / 1ps
module particle_repel_spring_step import prs_pkg::*; #(
  parameter int FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input: pos_x, pos_y, vel_x, vel_y, home_x, home_y, pointer_x, pointer_y
  input  logic [255:0]         in_tdata,
  // input: touched_in, button_down
  input  logic [1:0]           in_tuser,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // output: next_x, next_y, next_vx, next_vy
  output logic [127:0]         out_tdata,
  // output: touched_out, clipped
  output logic [1:0]           out_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int SHL   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int M_W   = NUM_W + U_W - 16;  // (q * u) >> 16
  localparam int CHG_W = M_W + SHL;
  localparam int VS_W  = CHG_W + 2;
  localparam int DV_W  = VS_W + 1;
  localparam int HR_W  = 34;
  localparam int PS_W  = 36;

  // ---------------- configuration registers ----------------
  logic [1:0]  mode_r;
  logic [30:0] strength_r;
  logic [31:0] radius_r;
  logic [15:0] damping_r;
  logic [15:0] rate_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_PLAIN;
      strength_r <= STRENGTH_RST;
      radius_r   <= RADIUS_RST;
      damping_r  <= DAMPING_RST;
      rate_r     <= RATE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:     mode_r     <= cfg_data[1:0];
        REG_STRENGTH: strength_r <= cfg_data[30:0];
        REG_RADIUS:   radius_r   <= cfg_data;
        REG_DAMPING:  damping_r  <= cfg_data[15:0];
        REG_RATE:     rate_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable / output buffer ----------------
  logic ce;
  logic skid_valid_r;
  assign ce        = !skid_valid_r;
  assign in_tready = ce;

  // ---------------- stage A: deltas and magnitudes ----------------
  logic signed [32:0] dx_w, dy_w;
  logic [32:0]        ax_w, ay_w;
  prs_item_t          it_a_r;
  logic               va_r, rok_a_r, btn_a_r;

  assign dx_w = $signed({in_tdata[223], in_tdata[223:192]}) - $signed({in_tdata[31], in_tdata[31:0]});
  assign dy_w = $signed({in_tdata[255], in_tdata[255:224]}) - $signed({in_tdata[63], in_tdata[63:32]});
  assign ax_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
  assign ay_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (ce) va_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      it_a_r.px      <= in_tdata[31:0];
      it_a_r.py      <= in_tdata[63:32];
      it_a_r.vx      <= in_tdata[95:64];
      it_a_r.vy      <= in_tdata[127:96];
      it_a_r.hx      <= in_tdata[159:128];
      it_a_r.hy      <= in_tdata[191:160];
      it_a_r.sx      <= S_W'(ax_w >> (FRAC_BITS - 8));
      it_a_r.sy      <= S_W'(ay_w >> (FRAC_BITS - 8));
      it_a_r.d2      <= '0;
      it_a_r.dx_pos  <= !dx_w[32] && (dx_w != 33'sd0);
      it_a_r.dy_pos  <= !dy_w[32] && (dy_w != 33'sd0);
      it_a_r.touched <= in_tuser[0];
      it_a_r.move    <= 1'b1;
      it_a_r.apply_f <= 1'b0;
      rok_a_r        <= ((ax_w >> (FRAC_BITS + 16)) == 33'd0) &&
                        ((ay_w >> (FRAC_BITS + 16)) == 33'd0);
      btn_a_r        <= in_tuser[1];
    end
  end

  // ---------------- stage B: squared distance ----------------
  prs_item_t       it_b_r;
  logic            vb_r, rok_b_r, btn_b_r;
  logic [D2_W:0]   d2_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (ce) vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      it_b_r  <= it_a_r;
      rok_b_r <= rok_a_r;
      btn_b_r <= btn_a_r;
      d2_b_r  <= (D2_W+1)'(it_a_r.sx * it_a_r.sx) + (D2_W+1)'(it_a_r.sy * it_a_r.sy);
    end
  end

  // ---------------- stage C: radius test and mode ----------------
  logic      inside_w, touched_w, move_w, force_w;
  prs_item_t it_c_nxt;
  prs_item_t it_c_r;
  logic      vc_r;

  assign inside_w = rok_b_r && (d2_b_r < {1'b0, radius_r, 16'd0});

  always_comb begin
    touched_w = it_b_r.touched;
    move_w    = 1'b1;
    force_w   = inside_w;
    unique case (mode_r)
      MODE_BUTTON: move_w = btn_b_r;
      MODE_LATCH: begin
        touched_w = it_b_r.touched || inside_w;
        move_w    = touched_w;
        force_w   = 1'b0;
      end
      default: ;  // plain repulsion; mode 3 acts the same
    endcase
  end

  always_comb begin
    it_c_nxt         = it_b_r;
    it_c_nxt.d2      = d2_b_r[D2_W-1:0];
    it_c_nxt.touched = touched_w;
    it_c_nxt.move    = move_w;
    it_c_nxt.apply_f = force_w && (d2_b_r != '0);  // zero distance: no force
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (ce) vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      it_c_r <= it_c_nxt;
    end
  end

  // ---------------- square root, then the three divisions ----------------
  localparam int IT_W = $bits(prs_item_t);

  logic            sq_valid;
  logic [R_W-1:0]  sq_root;
  prs_item_t       sq_it;

  prs_sqrt #(.PW(IT_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(ce),
    .in_valid(vc_r), .in_rad(it_c_r.d2), .in_pl(it_c_r),
    .out_valid(sq_valid), .out_root(sq_root), .out_pl(sq_it)
  );

  logic             dv_valid;
  logic [NUM_W-1:0] q_w;
  logic [U_W-1:0]   ux_w, uy_w;
  prs_item_t        dv_it;

  prs_div #(.PW(IT_W)) u_div (
    .clk(clk), .rst_n(rst_n), .en(ce),
    .in_valid(sq_valid),
    .num_q({strength_r, 16'd0}),
    .den_q(sq_it.d2),
    .num_x(NUM_W'({sq_it.sx, 16'd0})),
    .num_y(NUM_W'({sq_it.sy, 16'd0})),
    .den_u(sq_root),
    .in_pl(sq_it),
    .out_valid(dv_valid), .quo_q(q_w), .quo_x(ux_w), .quo_y(uy_w), .out_pl(dv_it)
  );

  // ---------------- M1: force times unit component ----------------
  prs_item_t            it_m1_r;
  logic                 v_m1_r;
  logic [NUM_W+U_W-1:0] prx_r, pry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_m1_r <= 1'b0;
    else if (ce) v_m1_r <= dv_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      it_m1_r <= dv_it;
      prx_r   <= q_w * ux_w;
      pry_r   <= q_w * uy_w;
    end
  end

  // ---------------- M2: velocity change, home offset ----------------
  logic [CHG_W-1:0]        mcx_w, mcy_w;
  logic signed [VS_W-1:0]  chx_w, chy_w;
  prs_item_t               it_m2_r;
  logic                    v_m2_r;
  logic signed [VS_W-1:0]  vsx_r, vsy_r;
  logic signed [32:0]      hdx_r, hdy_r;

  assign mcx_w = (CHG_W'(prx_r[NUM_W+U_W-1:16]) << SHL) >> SHR;
  assign mcy_w = (CHG_W'(pry_r[NUM_W+U_W-1:16]) << SHL) >> SHR;
  assign chx_w = !it_m1_r.apply_f ? '0 :
                 it_m1_r.dx_pos ? -$signed({2'b00, mcx_w}) : $signed({2'b00, mcx_w});
  assign chy_w = !it_m1_r.apply_f ? '0 :
                 it_m1_r.dy_pos ? -$signed({2'b00, mcy_w}) : $signed({2'b00, mcy_w});

  always_ff @(posedge clk) begin
    if (!rst_n) v_m2_r <= 1'b0;
    else if (ce) v_m2_r <= v_m1_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      it_m2_r <= it_m1_r;
      vsx_r   <= VS_W'($signed(it_m1_r.vx)) + chx_w;
      vsy_r   <= VS_W'($signed(it_m1_r.vy)) + chy_w;
      hdx_r   <= 33'($signed(it_m1_r.hx)) - 33'($signed(it_m1_r.px));
      hdy_r   <= 33'($signed(it_m1_r.hy)) - 33'($signed(it_m1_r.py));
    end
  end

  // ---------------- M3: damping and return scaling ----------------
  logic signed [VS_W+16:0] dpx_w, dpy_w;
  logic signed [49:0]      hpx_w, hpy_w;
  prs_item_t               it_m3_r;
  logic                    v_m3_r;
  logic signed [DV_W-1:0]  dvx_r, dvy_r;
  logic signed [HR_W-1:0]  hrx_r, hry_r;

  assign dpx_w = vsx_r * $signed({1'b0, damping_r});
  assign dpy_w = vsy_r * $signed({1'b0, damping_r});
  assign hpx_w = hdx_r * $signed({1'b0, rate_r});
  assign hpy_w = hdy_r * $signed({1'b0, rate_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v_m3_r <= 1'b0;
    else if (ce) v_m3_r <= v_m2_r;
  end

  // slicing off the low 16 bits is a floor divide by 2^16
  always_ff @(posedge clk) begin
    if (ce) begin
      it_m3_r <= it_m2_r;
      dvx_r   <= dpx_w[VS_W+16:16];
      dvy_r   <= dpy_w[VS_W+16:16];
      hrx_r   <= hpx_w[49:16];
      hry_r   <= hpy_w[49:16];
    end
  end

  // ---------------- M4: velocity saturation, position sum ----------------
  prs_sat_t               nvx_w, nvy_w;
  prs_item_t              it_m4_r;
  logic                   v_m4_r;
  prs_sat_t               nvx_r, nvy_r;
  logic signed [PS_W-1:0] psx_r, psy_r;

  assign nvx_w = sat32(SAT_W'(dvx_r));
  assign nvy_w = sat32(SAT_W'(dvy_r));

  always_ff @(posedge clk) begin
    if (!rst_n) v_m4_r <= 1'b0;
    else if (ce) v_m4_r <= v_m3_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      it_m4_r <= it_m3_r;
      nvx_r   <= nvx_w;
      nvy_r   <= nvy_w;
      psx_r   <= PS_W'($signed(it_m3_r.px)) + PS_W'($signed(nvx_w.val)) + PS_W'(hrx_r);
      psy_r   <= PS_W'($signed(it_m3_r.py)) + PS_W'($signed(nvy_w.val)) + PS_W'(hry_r);
    end
  end

  // ---------------- M5: position saturation, pass-through select ----------------
  prs_sat_t     nx_w, ny_w;
  logic [129:0] res_w;   // {clipped, touched, vy, vx, y, x}
  logic         clip_w;

  assign nx_w   = sat32(SAT_W'(psx_r));
  assign ny_w   = sat32(SAT_W'(psy_r));
  assign clip_w = it_m4_r.move && (nx_w.clip || ny_w.clip || nvx_r.clip || nvy_r.clip);

  always_comb begin
    if (it_m4_r.move) begin
      res_w = {clip_w, it_m4_r.touched, nvy_r.val, nvx_r.val, ny_w.val, nx_w.val};
    end else begin
      // not moving: values pass through and never count as clipped
      res_w = {1'b0, it_m4_r.touched, it_m4_r.vy, it_m4_r.vx, it_m4_r.py, it_m4_r.px};
    end
  end

  // ---------------- output register + skid ----------------
  logic         out_valid_r;
  logic [129:0] out_data_r, skid_data_r;
  logic         push_w;

  assign push_w = ce && v_m4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push_w;
      end
    end else if (push_w) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_w;
    end else if (push_w) begin
      skid_data_r <= res_w;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r[127:0];
  assign out_tuser  = out_data_r[129:128];

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && !skid_valid_r && v_m4_r) |=> skid_valid_r)
    else $error("result lost while receiver stalled");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_tready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not moved to output");

  a_cfg_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index == REG_MODE) |=> (mode_r == $past(cfg_data[1:0])))
    else $error("mode write not applied");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for particle_repel_spring_step: random and directed particles
// against a behavioral predictor, with bursty input and a stalling receiver.
// Depends on prs_pkg and the particle_repel_spring_step RTL.
`timescale 1ns / 1ps
module tb;
  import prs_pkg::*;

  typedef struct {
    logic [255:0] data;
    logic [1:0]   user;
  } particle_t;

  typedef struct {
    logic [127:0] data;
    logic [1:0]   user;
  } update_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [255:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  particle_repel_spring_step u_top (.*);

  // Configuration copy used by the predictor
  logic [1:0]  m_mode;
  logic [30:0] m_strength;
  logic [31:0] m_radius;
  logic [15:0] m_damping;
  logic [15:0] m_rate;

  particle_t pending_q[$];
  update_t   expected_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;

  initial forever #1 clk = ~clk;

  // Hard limit: 2000+ items at slow rates comfortably fit inside this
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("** particle_repel_spring_step: FAILED **");
      $finish;
    end
  end

  // floor(a * f / 2^16), arithmetic shift on a wide signed value floors
  function automatic logic signed [79:0] scale_q16(input logic signed [79:0] a,
                                                   input logic [15:0] f);
    logic signed [79:0] p;
    p = a * $signed({64'd0, f});
    return p >>> 16;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [79:0] v, inout logic clip);
    if (v > 80'sd2147483647) begin
      clip = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -80'sd2147483648) begin
      clip = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Repulsion velocity change along one axis (Q16.16 coordinates)
  function automatic logic signed [79:0] push(input logic signed [79:0] delta,
      input logic [63:0] s, input logic [63:0] q, input logic [63:0] d);
    logic [63:0] u, m;
    u = (s << 16) / d;
    m = (q * u) >> 16;
    return (delta > 0) ? -$signed({16'd0, m}) : $signed({16'd0, m});
  endfunction

  function automatic update_t step_particle(input particle_t p);
    logic signed [79:0] px, py, vx, vy, hx, hy, mx, my, dx, dy, ax, ay;
    logic [63:0] sx, sy, d2, d, q;
    logic touched, button, in_range, move, apply, clip;
    logic [31:0] nx, ny, nvx, nvy;
    update_t r;
    px = $signed(p.data[31:0]);    py = $signed(p.data[63:32]);
    vx = $signed(p.data[95:64]);   vy = $signed(p.data[127:96]);
    hx = $signed(p.data[159:128]); hy = $signed(p.data[191:160]);
    mx = $signed(p.data[223:192]); my = $signed(p.data[255:224]);
    touched = p.user[0];
    button = p.user[1];
    dx = mx - px;
    dy = my - py;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    in_range = 1'b0;
    d2 = 0;
    sx = 0;
    sy = 0;
    move = 1'b1;
    clip = 1'b0;
    if (ax < (80'sd1 <<< 32) && ay < (80'sd1 <<< 32)) begin
      sx = ax[63:0] >> 8;
      sy = ay[63:0] >> 8;
      d2 = sx * sx + sy * sy;
      in_range = d2 < ({32'd0, m_radius} << 16);
    end
    apply = in_range;
    if (m_mode == MODE_BUTTON) begin
      move = button;
    end else if (m_mode == MODE_LATCH) begin
      touched = touched | in_range;
      move = touched;
      apply = 1'b0;
    end
    nx = px[31:0]; ny = py[31:0]; nvx = vx[31:0]; nvy = vy[31:0];
    if (move) begin
      // zero distance: in range but no force
      if (apply && d2 != 0) begin
        d = int_sqrt(d2);
        q = ({33'd0, m_strength} << 16) / d2;
        vx = vx + push(dx, sx, q, d);
        vy = vy + push(dy, sy, q, d);
      end
      nvx = clamp32(scale_q16(vx, m_damping), clip);
      nvy = clamp32(scale_q16(vy, m_damping), clip);
      nx = clamp32(px + $signed(nvx) + scale_q16(hx - px, m_rate), clip);
      ny = clamp32(py + $signed(nvy) + scale_q16(hy - py, m_rate), clip);
    end
    r.data = {nvy, nvx, ny, nx};
    r.user = {clip, touched};
    return r;
  endfunction

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
  endtask

  // Driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(step_particle('{in_tdata, in_tuser}));
        void'(pending_q.pop_front());
      end
      if ((in_tvalid && in_tready) || !in_tvalid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_q[0].data;
          in_tuser <= pending_q[0].user;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall pattern on out_tready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transaction", out_tdata, '0);
        end else begin
          update_t e;
          e = expected_q.pop_front();
          if (out_tdata[31:0] !== e.data[31:0])
            report("next_x", 128'(out_tdata[31:0]), 128'(e.data[31:0]));
          if (out_tdata[63:32] !== e.data[63:32])
            report("next_y", 128'(out_tdata[63:32]), 128'(e.data[63:32]));
          if (out_tdata[95:64] !== e.data[95:64])
            report("next_vx", 128'(out_tdata[95:64]), 128'(e.data[95:64]));
          if (out_tdata[127:96] !== e.data[127:96])
            report("next_vy", 128'(out_tdata[127:96]), 128'(e.data[127:96]));
          if (out_tuser[0] !== e.user[0])
            report("touched_out", 128'(out_tuser[0]), 128'(e.user[0]));
          if (out_tuser[1] !== e.user[1])
            report("clipped", 128'(out_tuser[1]), 128'(e.user[1]));
        end
      end
      case (cycles % 1024 / 256)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(3, 0) != 0;
        2: out_tready <= $urandom_range(3, 0) == 0;
        default: out_tready <= ((cycles / 7) % 3) != 0;
      endcase
    end
  end

  function automatic logic [31:0] rnd_coord(input int kind);
    case (kind)
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $urandom_range(32'h01000000, 0) - 32'h00800000;
    endcase
  endfunction

  task automatic add_particle(input logic [31:0] px, py, vx, vy, hx, hy, mx, my,
                              input logic t, b);
    pending_q.push_back('{{my, mx, hy, hx, vy, vx, py, px}, {b, t}});
  endtask

  // Random particle; pointer mostly near the particle so the force path is hit
  task automatic add_random();
    logic [31:0] px, py, mx, my;
    int k;
    k = $urandom_range(9, 0);
    px = rnd_coord(k < 8 ? 3 : $urandom_range(2, 0));
    py = rnd_coord(k < 8 ? 3 : $urandom_range(2, 0));
    if (k < 7) begin
      mx = px + $urandom_range(32'h00c80000, 0) - 32'h00640000;
      my = py + $urandom_range(32'h00c80000, 0) - 32'h00640000;
      if (k == 0) begin
        mx = px;
        my = py;
      end
    end else begin
      mx = rnd_coord($urandom_range(3, 0));
      my = rnd_coord($urandom_range(3, 0));
    end
    add_particle(px, py, rnd_coord($urandom_range(3, 0)), rnd_coord($urandom_range(3, 0)),
                 rnd_coord($urandom_range(3, 0)), rnd_coord($urandom_range(3, 0)), mx, my,
                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
  endtask

  // One register write, then the channel is left idle before the task returns
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:     m_mode = val[1:0];
      REG_STRENGTH: m_strength = val[30:0];
      REG_RADIUS:   m_radius = val;
      REG_DAMPING:  m_damping = val[15:0];
      default:      m_rate = val[15:0];
    endcase
    @(posedge clk);
  endtask

  // Idle point: nothing pending, nothing expected, pipeline drained
  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_q.size() != 0 || in_tvalid || expected_q.size() != 0) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  initial begin
    m_mode = MODE_PLAIN;
    m_strength = STRENGTH_RST;
    m_radius = RADIUS_RST;
    m_damping = DAMPING_RST;
    m_rate = RATE_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, zero distance, out-of-range pointer, flags
    add_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_particle(32'h00100000, 32'h00100000, 0, 0, 0, 0, 32'h00100000, 32'h00100000, 0, 1);
    add_particle(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1, 1);
    add_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0);
    add_particle(32'h00010000, 32'hffff0000, 32'h00050000, 32'hfffb0000,
                 0, 0, 0, 0, 0, 1);
    add_particle(32'h00000100, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    add_particle(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_MODE, 32'(MODE_BUTTON));
        end
        2: begin
          write_reg(REG_MODE, 32'(MODE_LATCH));
          write_reg(REG_RADIUS, 32'hffffffff);
        end
        3: begin
          write_reg(REG_MODE, 32'd3);
          write_reg(REG_STRENGTH, 32'h7fffffff);
          write_reg(REG_DAMPING, 32'h0000ffff);
          write_reg(REG_RATE, 32'h0000ffff);
          write_reg(REG_RADIUS, 32'd40000);
        end
        4: begin
          write_reg(REG_MODE, 32'(MODE_PLAIN));
          write_reg(REG_STRENGTH, 32'd0);
          write_reg(REG_DAMPING, 32'd0);
          write_reg(REG_RATE, 32'd0);
          write_reg(REG_RADIUS, 32'd0);
        end
        5: begin
          write_reg(REG_MODE, 32'(MODE_BUTTON));
          write_reg(REG_STRENGTH, $urandom);
          write_reg(REG_RADIUS, $urandom_range(100000, 1));
          write_reg(REG_DAMPING, $urandom);
          write_reg(REG_RATE, $urandom);
        end
        6: begin
          write_reg(REG_MODE, 32'(MODE_LATCH));
          write_reg(REG_RADIUS, 32'd10000);
        end
        7: begin
          write_reg(REG_MODE, 32'(MODE_PLAIN));
          write_reg(REG_STRENGTH, 32'(STRENGTH_RST));
          write_reg(REG_DAMPING, 32'(DAMPING_RST));
          write_reg(REG_RATE, 32'(RATE_RST));
        end
        default: ;
      endcase
      for (int i = 0; i < 250; i++) add_random();
      drain();
    end

    if (errors == 0) begin
      $display("** particle_repel_spring_step: PASSED **");
    end else begin
      $display("** particle_repel_spring_step: FAILED **");
    end
    $finish;
  end
endmodule
